// ----- rtl/core/yrr_pkg.sv -----
// ----------------------------------------------------------------------------
// yrr_pkg
// Shared types, constants and helpers for the YUV 4:2:2 resize/rotate/RGB block.
// ----------------------------------------------------------------------------
package yrr_pkg;

  localparam int unsigned StoreAw   = 17;
  localparam int unsigned SizeW     = 9;
  localparam int unsigned DivW      = 17;
  localparam int unsigned DivSteps  = DivW;
  localparam int unsigned DefMaxW   = 256;
  localparam int unsigned DefMaxH   = 256;

  // register indexes
  localparam logic [2:0] RegSrcH = 3'd0;
  localparam logic [2:0] RegSrcW = 3'd1;
  localparam logic [2:0] RegDstH = 3'd2;
  localparam logic [2:0] RegDstW = 3'd3;
  localparam logic [2:0] RegRot  = 3'd4;

  // rotation codes
  localparam logic [1:0] RotLeft  = 2'd1;
  localparam logic [1:0] RotRight = 2'd2;

  // read select codes
  localparam logic [1:0] SelY  = 2'd0;
  localparam logic [1:0] SelCb = 2'd1;
  localparam logic [1:0] SelCr = 2'd2;

  // color coefficients, scaled by 10000
  localparam logic [14:0] KRCr  = 15'd14065;
  localparam logic [14:0] KGCb  = 15'd3455;
  localparam logic [14:0] KGCr  = 15'd7169;
  localparam logic [14:0] KBCb  = 15'd17790;
  // ceil(2^36 / 10000): exact floor(m / 10000) for m < 2^22
  localparam logic [22:0] RecipM     = 23'd6871948;
  localparam int unsigned RecipShift = 36;
  localparam logic [8:0]  ChromaBias = 9'd128;

  typedef struct packed {
    logic        action;
    logic [16:0] load_addr;
    logic [7:0]  load_byte;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
  } in_word_t;

  typedef struct packed {
    logic [15:0] dest_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        coord_error;
  } out_word_t;

  typedef struct packed {
    logic       cap_in;
    logic       div_init;
    logic       div_step;
    logic       addr_calc;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       lat_y;
    logic       lat_cb;
    logic       lat_cr;
    logic       mul1;
    logic       mul2;
    logic       out_load;
  } yrr_cmd_t;

  typedef struct packed {
    logic in_action;
    logic coord_err;
    logic out_busy;
  } yrr_status_t;

  // clamp a size register to 1..maxv
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v,
                                                 input int unsigned maxv);
    logic [SizeW-1:0] res;
    res = v;
    if (v == '0) res = SizeW'(1);
    else if (32'(v) > maxv) res = SizeW'(maxv);
    return res;
  endfunction

  function automatic logic [7:0] clip8(input logic signed [10:0] v);
    logic [7:0] res;
    res = v[7:0];
    if (v > 11'sd255) res = 8'hFF;
    else if (v < 11'sd0) res = 8'h00;
    return res;
  endfunction

endpackage

// ----- rtl/core/yuv422p_resize_rotate_rgb.sv -----
// ----------------------------------------------------------------------------
// yuv422p_resize_rotate_rgb
// Planar YUV 4:2:2 frame store with nearest-neighbor resize, rotation of the
// output placement and conversion to clipped RGB888.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 word
//  in       input      in_valid_i / in_stall_o   in_i  (yrr_pkg::in_word_t)
//  out      output     out_valid_o / out_stall_i out_o (yrr_pkg::out_word_t)
//  cfg      input      cfg_we_i, no wait         cfg_index_i, cfg_data_i
//
//  A load word writes its byte to the frame store at accept.
//  A convert word passes through two 17-step restoring dividers (run side
//  by side), then three reads on the single store port and two multiply
//  stages for the color terms. An out-of-range word skips to the output step.
//  Reset returns the controller and config registers to defaults and clears
//  output valid; the frame store is not cleared. A stalled output holds its
//  word; the next word waits in the last convert step until the output is free.
//
module yuv422p_resize_rotate_rgb #(
  parameter int unsigned MAX_WIDTH  = yrr_pkg::DefMaxW,
  parameter int unsigned MAX_HEIGHT = yrr_pkg::DefMaxH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  yrr_pkg::in_word_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output yrr_pkg::out_word_t out_o
);
  import yrr_pkg::*;

  yrr_cmd_t    cmd;
  yrr_status_t status;

  // sequence the convert steps
  yrr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, divide, address and color math
  yrr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- rtl/core/yrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// yrr_ctrl
// Sequencer for one input word: load write, or the convert steps.
// ----------------------------------------------------------------------------
module yrr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  yrr_pkg::yrr_status_t status_i,
  output yrr_pkg::yrr_cmd_t    cmd_o
);
  import yrr_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StChk   = 4'd1;
  localparam logic [3:0] StDiv   = 4'd2;
  localparam logic [3:0] StAddr  = 4'd3;
  localparam logic [3:0] StRdY   = 4'd4;
  localparam logic [3:0] StRdCb  = 4'd5;
  localparam logic [3:0] StRdCr  = 4'd6;
  localparam logic [3:0] StLatCr = 4'd7;
  localparam logic [3:0] StMul1  = 4'd8;
  localparam logic [3:0] StMul2  = 4'd9;
  localparam logic [3:0] StDone  = 4'd10;

  localparam int unsigned CntW = $clog2(DivSteps);

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (status_i.in_action) state_d = StChk;
        end
      end
      StChk: begin
        if (status_i.coord_err) begin
          state_d = StDone;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) state_d = StAddr;
      end
      StAddr: begin
        cmd_o.addr_calc = 1'b1;
        state_d = StRdY;
      end
      StRdY: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SelY;
        state_d = StRdCb;
      end
      StRdCb: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SelCb;
        cmd_o.lat_y  = 1'b1;
        state_d = StRdCr;
      end
      StRdCr: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SelCr;
        cmd_o.lat_cb = 1'b1;
        state_d = StLatCr;
      end
      StLatCr: begin
        cmd_o.lat_cr = 1'b1;
        state_d = StMul1;
      end
      StMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d = StMul2;
      end
      StMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/yrr_datapath.sv -----
// ----------------------------------------------------------------------------
// yrr_datapath
// Config registers, frame store, dividers, address and color arithmetic.
// ----------------------------------------------------------------------------
module yrr_datapath #(
  parameter int unsigned MAX_WIDTH  = yrr_pkg::DefMaxW,
  parameter int unsigned MAX_HEIGHT = yrr_pkg::DefMaxH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  input  yrr_pkg::in_word_t    in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output yrr_pkg::out_word_t   out_o,
  input  yrr_pkg::yrr_cmd_t    cmd_i,
  output yrr_pkg::yrr_status_t status_o
);
  import yrr_pkg::*;

  logic [SizeW-1:0] src_h_q, src_w_q, dst_h_q, dst_w_q;
  logic [1:0]       rot_q;
  logic [SizeW-1:0] sh, sw, dh, dw;

  logic [7:0]  row_q, col_q;
  logic        err_q;

  logic [DivW-1:0]  nr_q, nc_q;
  logic [SizeW:0]   remr_q, remc_q;
  logic [SizeW:0]   remr_s, remc_s;

  logic [StoreAw-1:0] ay_q, acb_q, acr_q, rd_addr;
  logic [7:0]         mem [2**StoreAw];
  logic [7:0]         rdata_q;
  logic [7:0]         y_q, cb_q, cr_q;

  logic [18:0] pix;
  logic [17:0] area;

  logic [8:0]  cbc, crc;
  logic [7:0]  cb_abs, cr_abs;
  logic        cb_neg_q, cr_neg_q;
  logic [21:0] m_rcr_q, m_gcb_q, m_gcr_q, m_bcb_q;
  logic [7:0]  q_rcr_q, q_gcb_q, q_gcr_q, q_bcb_q;
  logic [44:0] p_rcr, p_gcb, p_gcr, p_bcb;
  logic [15:0] idx_q, idx_d;

  logic signed [10:0] r_s, g_s, b_s;
  logic signed [10:0] t_rcr, t_gcb, t_gcr, t_bcb;
  logic               out_valid_q;
  out_word_t          out_q;

  assign sh = eff_size(src_h_q, MAX_HEIGHT);
  assign sw = eff_size(src_w_q, MAX_WIDTH);
  assign dh = eff_size(dst_h_q, MAX_HEIGHT);
  assign dw = eff_size(dst_w_q, MAX_WIDTH);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_h_q <= 9'd240;
      src_w_q <= 9'd240;
      dst_h_q <= 9'd192;
      dst_w_q <= 9'd192;
      rot_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSrcH: src_h_q <= cfg_data_i;
        RegSrcW: src_w_q <= cfg_data_i;
        RegDstH: dst_h_q <= cfg_data_i;
        RegDstW: dst_w_q <= cfg_data_i;
        RegRot:  rot_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign status_o.in_action = in_i.action;
  assign status_o.coord_err = err_q;
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  // capture convert coordinates
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      row_q <= in_i.out_row;
      col_q <= in_i.out_col;
      err_q <= (9'(in_i.out_row) >= dh) || (9'(in_i.out_col) >= dw);
    end
  end

  // restoring dividers, one quotient bit per step
  assign remr_s = {remr_q[SizeW-1:0], nr_q[DivW-1]};
  assign remc_s = {remc_q[SizeW-1:0], nc_q[DivW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      nr_q   <= 17'(row_q) * 17'(sh);
      nc_q   <= 17'(col_q) * 17'(sw);
      remr_q <= '0;
      remc_q <= '0;
    end else if (cmd_i.div_step) begin
      if (remr_s >= {1'b0, dh}) begin
        remr_q <= remr_s - {1'b0, dh};
        nr_q   <= {nr_q[DivW-2:0], 1'b1};
      end else begin
        remr_q <= remr_s;
        nr_q   <= {nr_q[DivW-2:0], 1'b0};
      end
      if (remc_s >= {1'b0, dw}) begin
        remc_q <= remc_s - {1'b0, dw};
        nc_q   <= {nc_q[DivW-2:0], 1'b1};
      end else begin
        remc_q <= remc_s;
        nc_q   <= {nc_q[DivW-2:0], 1'b0};
      end
    end
  end

  // store addresses, wrapping at the store depth
  assign pix  = 19'(nr_q[SizeW-1:0]) * 19'(sw) + 19'(nc_q[SizeW-1:0]);
  assign area = 18'(sh) * 18'(sw);

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_calc) begin
      ay_q  <= pix[StoreAw-1:0];
      acb_q <= area[StoreAw-1:0] + pix[StoreAw:1];
      acr_q <= area[StoreAw-1:0] + area[StoreAw:1] + pix[StoreAw:1];
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      SelCb:   rd_addr = acb_q;
      SelCr:   rd_addr = acr_q;
      default: rd_addr = ay_q;
    endcase
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in && !in_i.action) mem[in_i.load_addr] <= in_i.load_byte;
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_y)  y_q  <= rdata_q;
    if (cmd_i.lat_cb) cb_q <= rdata_q;
    if (cmd_i.lat_cr) cr_q <= rdata_q;
  end

  // chroma magnitude and sign
  assign cbc    = {1'b0, cb_q} - ChromaBias;
  assign crc    = {1'b0, cr_q} - ChromaBias;
  assign cb_abs = cbc[8] ? 8'(ChromaBias - {1'b0, cb_q}) : cbc[7:0];
  assign cr_abs = crc[8] ? 8'(ChromaBias - {1'b0, cr_q}) : crc[7:0];

  always_comb begin
    case (rot_q)
      RotLeft:  idx_d = 16'((dw - 9'd1 - 9'(col_q)) * dh + 9'(row_q));
      RotRight: idx_d = 16'(9'(col_q) * dh + (dh - 9'd1 - 9'(row_q)));
      default:  idx_d = 16'(9'(row_q) * dw + 9'(col_q));
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      m_rcr_q  <= 22'(KRCr * 15'(cr_abs));
      m_gcb_q  <= 22'(KGCb * 15'(cb_abs));
      m_gcr_q  <= 22'(KGCr * 15'(cr_abs));
      m_bcb_q  <= 22'(KBCb * 15'(cb_abs));
      cb_neg_q <= cbc[8];
      cr_neg_q <= crc[8];
      idx_q    <= idx_d;
    end
  end

  // divide by 10000 through the reciprocal
  assign p_rcr = 45'(m_rcr_q) * 45'(RecipM);
  assign p_gcb = 45'(m_gcb_q) * 45'(RecipM);
  assign p_gcr = 45'(m_gcr_q) * 45'(RecipM);
  assign p_bcb = 45'(m_bcb_q) * 45'(RecipM);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      q_rcr_q <= p_rcr[RecipShift +: 8];
      q_gcb_q <= p_gcb[RecipShift +: 8];
      q_gcr_q <= p_gcr[RecipShift +: 8];
      q_bcb_q <= p_bcb[RecipShift +: 8];
    end
  end

  assign t_rcr = cr_neg_q ? -$signed(11'(q_rcr_q)) : $signed(11'(q_rcr_q));
  assign t_gcr = cr_neg_q ? -$signed(11'(q_gcr_q)) : $signed(11'(q_gcr_q));
  assign t_gcb = cb_neg_q ? -$signed(11'(q_gcb_q)) : $signed(11'(q_gcb_q));
  assign t_bcb = cb_neg_q ? -$signed(11'(q_bcb_q)) : $signed(11'(q_bcb_q));

  assign r_s = $signed(11'(y_q)) + t_rcr;
  assign g_s = $signed(11'(y_q)) - t_gcb - t_gcr;
  assign b_s = $signed(11'(y_q)) + t_bcb;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (err_q) begin
        out_q.dest_index  <= '0;
        out_q.red         <= '0;
        out_q.green       <= '0;
        out_q.blue        <= '0;
        out_q.coord_error <= 1'b1;
      end else begin
        out_q.dest_index  <= idx_q;
        out_q.red         <= clip8(r_s);
        out_q.green       <= clip8(g_s);
        out_q.blue        <= clip8(b_s);
        out_q.coord_error <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
